FILE: design/ascii_range_frame_parser_macros.svh
// Assertion macros for the range frame parser. They expand to nothing in synthesis.
`ifndef ASCII_RANGE_FRAME_PARSER_MACROS_SVH
`define ASCII_RANGE_FRAME_PARSER_MACROS_SVH

`ifndef SYNTHESIS

// A property that is checked only while reset is released.
`define ARFP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A property that must hold at every edge, reset included.
`define ARFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ARFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARFP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: design/arfp_pkg.sv
package arfp_pkg;

    localparam logic [7:0]  START_BYTE  = 8'd82;
    localparam logic [7:0]  END_BYTE    = 8'd13;
    localparam logic [7:0]  DIGIT_ZERO  = 8'h30;
    localparam logic [7:0]  DIGIT_NINE  = 8'h39;
    localparam logic [13:0] RANGE_MAX   = 14'h3FFF;
    // The accumulator parks one above the largest range once it overflows.
    localparam logic [14:0] ACC_SAT     = 15'h4000;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_STORED  = 3'd1,
        STATUS_START   = 3'd2,
        STATUS_BAD_END = 3'd3,
        STATUS_HUNT    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        PS_HUNT,
        PS_COLLECT,
        PS_AWAIT_END
    } t_parse_state;

    typedef struct packed {
        t_status     status;
        logic [13:0] new_distance;
        logic [13:0] held_distance;
        logic [2:0]  bytes_held;
        logic        in_frame;
    } t_result;

endpackage

FILE: design/arfp_in_stage.sv
module arfp_in_stage import arfp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_advance,
    output logic       o_in_stall,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       accept;

    // The held word may leave in the same cycle as a new one arrives.
    assign o_in_stall = r_valid && !i_advance;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

FILE: design/arfp_parse_core.sv
module arfp_parse_core import arfp_pkg::*; #(
    parameter int PAYLOAD_BYTES = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_byte,
    output t_result    o_result
);

    localparam int CW = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [CW-1:0] LAST_SLOT = CW'(PAYLOAD_BYTES - 1);

    t_parse_state    r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [13:0]     r_last,  n_last;
    logic [14:0]     r_acc,   n_acc;
    logic            r_halt,  n_halt;

    logic            is_digit;
    logic [7:0]      digit_off;
    logic [17:0]     scaled;
    logic [14:0]     acc_step;
    logic [13:0]     fresh;
    logic [CW+2:0]   count_ext;
    t_status         status;
    logic [13:0]     new_dist;

    // The number is built as the payload arrives, so the terminator only
    // has to clamp the running value.
    always_comb begin
        is_digit  = (i_byte inside {[DIGIT_ZERO:DIGIT_NINE]});
        digit_off = i_byte - DIGIT_ZERO;
        scaled    = ({3'b000, r_acc} << 3) + ({3'b000, r_acc} << 1)
                    + {14'd0, digit_off[3:0]};
        acc_step  = (scaled > {4'd0, RANGE_MAX}) ? ACC_SAT : scaled[14:0];
        fresh     = (r_acc > {1'b0, RANGE_MAX}) ? RANGE_MAX : r_acc[13:0];
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_last   = r_last;
        n_acc    = r_acc;
        n_halt   = r_halt;
        status   = STATUS_HUNT;
        new_dist = 14'd0;
        case (r_state)
            PS_HUNT: begin
                n_count = '0;
                if (i_byte == START_BYTE) begin
                    n_state = PS_COLLECT;
                    n_acc   = '0;
                    n_halt  = 1'b0;
                    status  = STATUS_START;
                end else begin
                    status  = STATUS_HUNT;
                end
            end
            PS_COLLECT: begin
                n_count = r_count + 1'b1;
                status  = STATUS_STORED;
                // Conversion stops for good at the first non-digit.
                if (!r_halt && is_digit) begin
                    n_acc = acc_step;
                end else begin
                    n_halt = 1'b1;
                end
                if (r_count == LAST_SLOT) begin
                    n_state = PS_AWAIT_END;
                end
            end
            PS_AWAIT_END: begin
                n_state = PS_HUNT;
                n_count = '0;
                if (i_byte == END_BYTE) begin
                    n_last   = fresh;
                    new_dist = fresh;
                    status   = STATUS_OK;
                end else begin
                    status   = STATUS_BAD_END;
                end
            end
            default: begin
                n_state = PS_HUNT;
                n_count = '0;
            end
        endcase
    end

    assign count_ext = {3'b000, n_count};

    always_comb begin
        o_result.status        = status;
        o_result.new_distance  = new_dist;
        o_result.held_distance = n_last;
        o_result.bytes_held    = count_ext[2:0];
        o_result.in_frame      = (n_state != PS_HUNT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= PS_HUNT;
            r_count <= '0;
            r_last  <= '0;
        end else if (i_step) begin
            r_state <= n_state;
            r_count <= n_count;
            r_last  <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_acc  <= n_acc;
            r_halt <= n_halt;
        end
    end

endmodule

FILE: design/ascii_range_frame_parser.sv
// Range frame parser for an ASCII sensor link.
// Input channel: one received byte (i_rx_byte) per word, qualified by
// i_in_valid and held off by o_in_stall. The parser hunts for 'R', collects
// PAYLOAD_BYTES payload bytes and expects a carriage return after them; a
// good frame is converted from decimal digits into a range of at most 16383.
// Output channel: exactly one result word per input word, qualified by
// o_out_valid and held off by i_out_stall. It carries a status code, the
// freshly decoded range (zero unless the frame was good), the last good
// range, the payload count and the open-frame flag, all after that byte.
// A word accepted from the input channel is registered in the input stage,
// and its result is registered in the result register, from which it is
// offered. Throughput is one word per cycle while the receiver does not
// stall, set by the combinational parse and decode step between the two
// registers. When the receiver stalls, the result register holds its word
// and an empty input stage takes one more byte before o_in_stall rises.
// Reset (synchronous, active low) empties both stages, closes any frame and
// clears the stored range to zero.
`include "ascii_range_frame_parser_macros.svh"

module ascii_range_frame_parser import arfp_pkg::*; #(
    parameter int PAYLOAD_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_status,
    output logic [13:0] o_new_distance,
    output logic [13:0] o_held_distance,
    output logic [2:0]  o_bytes_held,
    output logic        o_in_frame
);

    logic    stage_valid;
    logic [7:0] stage_byte;
    logic    advance;
    t_result core_result;

    logic    r_out_valid;
    t_result r_out;

    // The held byte moves on whenever the result register is free or is
    // being emptied in this very cycle.
    assign advance = stage_valid && (!r_out_valid || !i_out_stall);

    arfp_in_stage u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_rx_byte  (i_rx_byte),
        .i_advance  (advance),
        .o_in_stall (o_in_stall),
        .o_valid    (stage_valid),
        .o_byte     (stage_byte)
    );

    // The parser state only moves when its result is captured below.
    arfp_parse_core #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_parse_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_byte   (stage_byte),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= core_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out.status;
    assign o_new_distance  = r_out.new_distance;
    assign o_held_distance = r_out.held_distance;
    assign o_bytes_held    = r_out.bytes_held;
    assign o_in_frame      = r_out.in_frame;

    // A good frame updates the stored range with the value it reports.
    `ARFP_ASSERT(a_ok_updates_held, i_clk, i_rst_n, (o_out_valid && o_status == STATUS_OK) |-> (o_new_distance == o_held_distance), "good frame range not stored")
    // Only a good frame may report a fresh range.
    `ARFP_ASSERT(a_fresh_only_on_ok, i_clk, i_rst_n, (o_out_valid && o_status != STATUS_OK) |-> (o_new_distance == 14'd0), "fresh range outside a good frame")
    // An open frame follows only a start byte or a stored payload byte.
    `ARFP_ASSERT(a_open_frame_status, i_clk, i_rst_n, (o_out_valid && o_in_frame) |-> (o_status == STATUS_STORED || o_status == STATUS_START), "frame open after a closing status")
    // The input side only backs up when the result register is full and blocked.
    `ARFP_ASSERT_ALWAYS(a_stall_cause, i_clk, o_in_stall |-> (o_out_valid && i_out_stall), "input stalled without output back-pressure")

endmodule

FILE: bench/range_frame_checker.sv
module range_frame_checker import arfp_pkg::*; #(
    parameter int PAYLOAD_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_status,
    input  logic [13:0] i_new_distance,
    input  logic [13:0] i_held_distance,
    input  logic [2:0]  i_bytes_held,
    input  logic        i_in_frame,
    output int          o_mismatches,
    output int          o_outstanding,
    output int          o_good_frames,
    output int          o_bad_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    // Shadow copy of the parser state.
    bit          frame_seen;
    int unsigned digits_taken;
    logic [7:0]  digit_buf [PAYLOAD_BYTES];
    logic [13:0] last_good_range;

    t_result     pending_results [$];
    int          fault_count;
    int          good_count;
    int          bad_end_count;

    // Advances the shadow state by one received byte and returns the result
    // word that the parser should produce for it.
    function automatic t_result parse_rx_byte(input logic [7:0] rx);
        t_result     r;
        int unsigned acc;
        bit          stopped;
        r       = '0;
        acc     = 0;
        stopped = 1'b0;
        if (frame_seen && digits_taken >= PAYLOAD_BYTES) begin
            if (rx == END_BYTE) begin
                // Decimal conversion halts at the first byte outside 0..9.
                for (int i = 0; i < PAYLOAD_BYTES; i++) begin
                    if (!stopped) begin
                        if (digit_buf[i] < DIGIT_ZERO || digit_buf[i] > DIGIT_NINE) begin
                            stopped = 1'b1;
                        end else begin
                            acc = acc * 10 + (digit_buf[i] - DIGIT_ZERO);
                            if (acc > RANGE_MAX) acc = RANGE_MAX + 1;
                        end
                    end
                end
                if (acc > RANGE_MAX) acc = RANGE_MAX;
                last_good_range = acc[13:0];
                r.status        = STATUS_OK;
                r.new_distance  = acc[13:0];
            end else begin
                r.status = STATUS_BAD_END;
            end
            frame_seen   = 1'b0;
            digits_taken = 0;
        end else if (frame_seen) begin
            digit_buf[digits_taken] = rx;
            digits_taken++;
            r.status = STATUS_STORED;
        end else if (rx == START_BYTE) begin
            frame_seen   = 1'b1;
            digits_taken = 0;
            r.status     = STATUS_START;
        end else begin
            digits_taken = 0;
            r.status     = STATUS_HUNT;
        end
        r.held_distance = last_good_range;
        r.bytes_held    = digits_taken[2:0];
        r.in_frame      = frame_seen;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            frame_seen      = 1'b0;
            digits_taken    = 0;
            last_good_range = '0;
            pending_results.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                pending_results.push_back(parse_rx_byte(i_rx_byte));
            end
            if (i_out_valid && !i_out_stall) begin
                got.status        = t_status'(i_status);
                got.new_distance  = i_new_distance;
                got.held_distance = i_held_distance;
                got.bytes_held    = i_bytes_held;
                got.in_frame      = i_in_frame;
                if (pending_results.size() == 0) begin
                    if (fault_count < 10) begin
                        $display("%0t: result word with nothing expected: status %0d new %0d held %0d count %0d open %0d",
                                 $time, got.status, got.new_distance, got.held_distance,
                                 got.bytes_held, got.in_frame);
                    end
                    fault_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (want.status == STATUS_OK) good_count++;
                    if (want.status == STATUS_BAD_END) bad_end_count++;
                    if (want != got) begin
                        if (fault_count < 10) begin
                            $display("%0t: mismatch: expected status %0d new %0d held %0d count %0d open %0d",
                                     $time, want.status, want.new_distance, want.held_distance,
                                     want.bytes_held, want.in_frame);
                            $display("%0t:           got status %0d new %0d held %0d count %0d open %0d",
                                     $time, got.status, got.new_distance, got.held_distance,
                                     got.bytes_held, got.in_frame);
                        end
                        fault_count++;
                    end
                end
            end
        end
        o_mismatches  <= fault_count;
        o_outstanding <= pending_results.size();
        o_good_frames <= good_count;
        o_bad_ends    <= bad_end_count;
    end

endmodule

FILE: bench/ascii_range_frame_parser_tb.sv
module ascii_range_frame_parser_tb import arfp_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD_BYTES    = 4;
    localparam int ITEM_TARGET      = 700;
    // The final stretch of the run is sent with neither side idling.
    localparam int QUIET_TAIL_ITEMS = 120;
    localparam int LONG_HOLD_AT     = 150;
    localparam int LONG_HOLD_CYCLES = 40;
    // Far beyond the longest legitimate gap: a long hold plus a few bursts.
    localparam int WATCHDOG_LIMIT   = 2000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [2:0]  o_status;
    logic [13:0] o_new_distance;
    logic [13:0] o_held_distance;
    logic [2:0]  o_bytes_held;
    logic        o_in_frame;

    int          mismatches;
    int          outstanding;
    int          good_frames;
    int          bad_ends;
    int          bytes_sent;
    int          idle_cycles;
    bit          quiet_tail;
    bit          calm;

    ascii_range_frame_parser #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_status       (o_status),
        .o_new_distance (o_new_distance),
        .o_held_distance(o_held_distance),
        .o_bytes_held   (o_bytes_held),
        .o_in_frame     (o_in_frame)
    );

    // The checker sits beside the parser, sees both channels and predicts
    // every result word on its own; the top only drives and judges.
    range_frame_checker #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_frame_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_rx_byte      (i_rx_byte),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_status       (o_status),
        .i_new_distance (o_new_distance),
        .i_held_distance(o_held_distance),
        .i_bytes_held   (o_bytes_held),
        .i_in_frame     (o_in_frame),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding),
        .o_good_frames  (good_frames),
        .o_bad_ends     (bad_ends)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // Offers one byte and holds it steady until the parser takes it. Now and
    // then the sender goes quiet for a short burst afterwards, unless the
    // current frame is meant to be sent back to back or the tail has begun.
    task automatic send_byte(input logic [7:0] rx);
        i_in_valid <= 1'b1;
        i_rx_byte  <= rx;
        do @(posedge i_clk); while (o_in_stall);
        bytes_sent++;
        if (!quiet_tail && !calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // Stops offering words and waits until every expected result has been
    // taken from the parser.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // Receiver: short random stall bursts, plus a single long hold once a
    // fair number of results have gone by. During the long hold the sender
    // keeps offering, so both parser stages fill and the input is held off.
    initial begin
        int  results_seen;
        bit  long_hold_done;
        results_seen   = 0;
        long_hold_done = 1'b0;
        i_out_stall    = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) results_seen++;
            if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (i_rst_n && !quiet_tail && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: a run in which no word moves on either channel for too long
    // has hung.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no word accepted for %0d cycles", idle_cycles);
                $display("ascii_range_frame_parser_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] directed [$];
        logic [7:0] rx;
        bit         mid_drained;
        int         pick;

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_byte   = 8'h00;
        quiet_tail  = 1'b0;
        calm        = 1'b0;
        bytes_sent  = 0;
        mid_drained = 1'b0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening: all-zero and all-one bytes while hunting, the
        // largest four-digit value, digits cut short by a colon (just above '9'), a
        // start byte inside a frame giving a payload with no leading digit
        // and a slash (just below '0'), and an all-zero payload ended badly.
        directed = {8'h00, 8'hFF,
                    START_BYTE, "9", "9", "9", "9", END_BYTE,
                    START_BYTE, "1", "2", ":", "4", END_BYTE,
                    START_BYTE, START_BYTE, "/", "5", "0", END_BYTE,
                    START_BYTE, "0", "0", "0", "0", 8'hFF};
        foreach (directed[i]) send_byte(directed[i]);
        drain_results();

        // Random part: mostly whole frames with random content, some of them
        // badly terminated, broken up by runs of arbitrary bytes. A stray
        // start byte in the noise shifts the framing of what follows.
        while (bytes_sent < ITEM_TARGET) begin
            if (!mid_drained && bytes_sent >= ITEM_TARGET / 2) begin
                drain_results();
                mid_drained = 1'b1;
            end
            quiet_tail = (bytes_sent >= ITEM_TARGET - QUIET_TAIL_ITEMS);
            calm       = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) < 2) begin
                repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
            end else begin
                send_byte(START_BYTE);
                for (int k = 0; k < PAYLOAD_BYTES; k++) begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7) begin
                        rx = DIGIT_ZERO + 8'($urandom_range(0, 9));
                    end else if (pick == 7) begin
                        rx = START_BYTE;
                    end else begin
                        rx = 8'($urandom_range(0, 255));
                    end
                    send_byte(rx);
                end
                if ($urandom_range(0, 6) == 0) begin
                    send_byte(8'($urandom_range(0, 255)));
                end else begin
                    send_byte(END_BYTE);
                end
            end
        end

        drain_results();
        repeat (4) @(posedge i_clk);

        $display("run covered %0d bytes: %0d frames decoded, %0d bad terminators,",
                 bytes_sent, good_frames, bad_ends);
        $display("random stalls on both sides and one long hold on the result side");
        if (mismatches == 0 && outstanding == 0) begin
            $display("ascii_range_frame_parser_tb: done, clean");
        end else begin
            $display("ascii_range_frame_parser_tb: done, errors");
        end
        $finish;
    end

endmodule
